// ----- rtl/hvg_pkg.sv -----
// Shared constants, types and register codes for the height map vertex generator.
package hvg_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int COLS_W      = $clog2(MAX_COLUMNS + 1);

  localparam logic [15:0] ONE_Q15 = 16'd32768;
  localparam logic [24:0] POS_MAX = 25'h1FFFFFF;
  localparam int          VEC_W   = 26;

  localparam logic [10:0] RST_GRID_COLUMNS = 11'd1024;
  localparam logic [15:0] RST_GRID_ROWS    = 16'd1024;
  localparam logic [23:0] RST_CELL_SIZE    = 24'd19200;
  localparam logic [23:0] RST_HEIGHT_SCALE = 24'd3276800;

  localparam logic [1:0] CFG_GRID_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_GRID_ROWS    = 2'd1;
  localparam logic [1:0] CFG_CELL_SIZE    = 2'd2;
  localparam logic [1:0] CFG_HEIGHT_SCALE = 2'd3;

  // face vector, components signed
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  // unit normal, Q1.15
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } nrm_t;

endpackage

// ----- rtl/hvg_if.sv -----
// Handshake channels: height samples in, vertices out, register writes.
interface hvg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] height;
  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

interface hvg_out_if;
  logic               valid;
  logic               ready;
  logic [24:0]        pos_x;
  logic [24:0]        pos_y;
  logic [24:0]        pos_z;
  logic [15:0]        colour_red;
  logic [15:0]        colour_blue;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               last;
  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output colour_red, output colour_blue, output normal_x,
                  output normal_y, output normal_z, output last, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input colour_red, input colour_blue, input normal_x,
                  input normal_y, input normal_z, input last, output ready);
endinterface

interface hvg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/hvg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hvg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/hvg_norm.sv -----
// Unit normal: sum of squares, shift normalize, bitwise square root, long division.
module hvg_norm import hvg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  vec_t vec,
  output logic done,
  output nrm_t nrm
);

  typedef enum logic [2:0] {
    N_IDLE, N_SQ, N_CHK, N_NORM, N_SQRT, N_DIVI, N_DIV, N_DONE
  } st_t;

  st_t         st;
  logic [1:0]  idx;
  logic [30:0] m [3];
  logic [2:0]  neg;
  logic [63:0] sq;
  logic [63:0] res;
  logic [63:0] bitr;
  logic [32:0] rem;
  logic [16:0] low;
  logic [16:0] q;
  logic [4:0]  dcnt;
  logic signed [15:0] n [3];

  logic signed [VEC_W-1:0] comp [3];
  logic [47:0] prod;
  logic [63:0] trial;
  logic [47:0] dvd;
  logic [31:0] dsr;
  logic [32:0] tmp;
  logic        take;
  logic [16:0] q_next;

  function automatic logic signed [15:0] clamp_q(input logic [16:0] qv, input logic ng);
    logic [16:0] qc;
    begin
      if (ng) begin
        qc = (qv > 17'd32768) ? 17'd32768 : qv;
        clamp_q = 16'(17'd0 - qc);
      end else begin
        qc = (qv > 17'd32767) ? 17'd32767 : qv;
        clamp_q = 16'(qc);
      end
    end
  endfunction

  assign comp[0] = vec.x;
  assign comp[1] = vec.y;
  assign comp[2] = vec.z;

  assign prod   = 48'(m[idx][23:0]) * 48'(m[idx][23:0]);
  assign trial  = res + bitr;
  assign dvd    = {1'b0, m[idx], 16'd0} + 48'(res);
  assign dsr    = {res[30:0], 1'b0};
  assign tmp    = {rem[31:0], low[16]};
  assign take   = (tmp >= {1'b0, dsr});
  assign q_next = {q[15:0], take};
  assign done   = (st == N_DONE);
  assign nrm    = '{x: n[0], y: n[1], z: n[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= N_IDLE;
    end else begin
      unique case (st)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= comp[i][VEC_W-1];
              m[i]   <= 31'(comp[i][VEC_W-1] ? (-comp[i]) : comp[i]);
            end
            sq  <= '0;
            idx <= '0;
            st  <= N_SQ;
          end
        end
        N_SQ: begin
          sq  <= sq + 64'(prod);
          idx <= idx + 2'd1;
          if (idx == 2'd2) begin
            st <= N_CHK;
          end
        end
        N_CHK: begin
          if (sq == '0) begin
            for (int i = 0; i < 3; i++) n[i] <= '0;
            st <= N_DONE;
          end else begin
            st <= N_NORM;
          end
        end
        N_NORM: begin
          // shift until the square sits in [2^60, 2^62); magnitudes follow by one
          if (sq < (64'd1 << 60)) begin
            sq <= sq << 2;
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            res  <= '0;
            bitr <= 64'd1 << 62;
            st   <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (sq >= trial) begin
            sq  <= sq - trial;
            res <= (res >> 1) + bitr;
          end else begin
            res <= res >> 1;
          end
          bitr <= bitr >> 2;
          if (bitr == 64'd1) begin
            idx <= '0;
            st  <= N_DIVI;
          end
        end
        N_DIVI: begin
          // quotient stays below 2^17, so the top bits start the remainder
          rem  <= {2'b00, dvd[47:17]};
          low  <= dvd[16:0];
          q    <= '0;
          dcnt <= '0;
          st   <= N_DIV;
        end
        N_DIV: begin
          rem  <= take ? (tmp - {1'b0, dsr}) : tmp;
          q    <= q_next;
          low  <= low << 1;
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd16) begin
            n[idx] <= clamp_q(q_next, neg[idx]);
            if (idx == 2'd2) begin
              st <= N_DONE;
            end else begin
              idx <= idx + 2'd1;
              st  <= N_DIVI;
            end
          end
        end
        N_DONE: begin
          st <= N_IDLE;
        end
        default: st <= N_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/heightmap_triangle_vertex_gen_core.sv -----
// Top level of the height map vertex generator: sample sequencing and vertex output.
//
// Height samples (Q1.15) come in raster order; the previous row lives in a
// one-port-read, one-port-write line buffer RAM and the left and above-left
// samples in registers. Each sample past the first row and first column
// closes a grid cell and yields six vertices (v1 v2 v3 v1 v3 v4) with
// position, colour and the face normal of their triangle; last marks the
// sixth. A sample that closes no cell passes only its accept and the line
// buffer read. A cell passes from its accept to its first vertex through
// the line buffer read, the shared 24x24 multiplier for heights and
// positions, then two passes of the normal unit, each a start, a sum of
// squares, a zero check (which ends the pass for a zero face vector),
// shift normalization, a 32-step square root, three long divisions and a
// done state. The six vertices then leave one per cycle as the sink takes
// them. A new sample is taken only once the previous one has delivered all
// its vertices. Register writes are taken in any cycle and act at once; the
// row and column counters are not reset by them.
module heightmap_triangle_vertex_gen_core import hvg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hvg_in_if.sink     sample,
  hvg_out_if.source  vertex,
  hvg_cfg_if.sink    cfg
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_NRM1, S_NRM2, S_EMIT} state_t;

  // config registers
  logic [10:0] grid_columns;
  logic [15:0] grid_rows;
  logic [23:0] cell_size;
  logic [23:0] height_scale;

  // stream state
  logic [15:0]      upper_left;
  logic [15:0]      left_sample;
  logic [COL_W-1:0] column_index;
  logic [15:0]      row_index;

  // current cell
  state_t           state;
  logic [15:0]      cur_h, cur_left, cur_ul, cur_above, cur_r;
  logic [COL_W-1:0] cur_c;
  logic [24:0]      z1, z2, z3, z4, px0, px1, py0, py1;
  nrm_t             n1, n2;
  logic [2:0]       mcnt, vcnt;
  logic             nstart;

  logic [15:0]       h_sat, above;
  logic [COL_W-1:0]  c_eff;
  logic [COLS_W-1:0] cols;
  logic [15:0]       rows;
  logic              col_wrap;
  logic [23:0]       ma, mb;
  logic [47:0]       prod;
  logic [24:0]       prod_z, prod_p;
  vec_t              nvec;
  logic              ndone;
  nrm_t              nres;
  logic [2:0]        sel_k;

  typedef struct packed {
    logic [24:0] x, y, z;
    logic [15:0] h;
    nrm_t        n;
    logic        last;
  } vtx_t;
  vtx_t vsel;

  assign h_sat = (sample.height > ONE_Q15) ? ONE_Q15 : sample.height;
  assign c_eff = (32'(column_index) >= MAX_COLUMNS) ? '0 : column_index;

  always_comb begin
    if (grid_columns < 11'd2) begin
      cols = COLS_W'(2);
    end else if (32'(grid_columns) > MAX_COLUMNS) begin
      cols = COLS_W'(MAX_COLUMNS);
    end else begin
      cols = COLS_W'(grid_columns);
    end
  end
  assign rows     = (grid_rows < 16'd2) ? 16'd2 : grid_rows;
  assign col_wrap = (32'(cur_c) + 32'd1 >= 32'(cols));

  hvg_ram #(.WIDTH(16), .DEPTH(MAX_COLUMNS)) u_line (
    .clk   (clk),
    .we    (state == S_READ),
    .waddr (cur_c),
    .wdata (cur_h),
    .raddr (c_eff),
    .rdata (above)
  );

  // shared multiplier: four heights times scale, then four grid positions
  always_comb begin
    unique case (mcnt)
      3'd0:    begin ma = 24'(cur_ul);    mb = height_scale; end
      3'd1:    begin ma = 24'(cur_left);  mb = height_scale; end
      3'd2:    begin ma = 24'(cur_h);     mb = height_scale; end
      3'd3:    begin ma = 24'(cur_above); mb = height_scale; end
      3'd4:    begin ma = 24'(cur_r - 16'd1); mb = cell_size; end
      3'd5:    begin ma = 24'(cur_r);     mb = cell_size; end
      3'd6:    begin ma = 24'(cur_c - COL_W'(1)); mb = cell_size; end
      default: begin ma = 24'(cur_c);     mb = cell_size; end
    endcase
  end
  assign prod   = 48'(ma) * 48'(mb);
  assign prod_z = prod[39:15];
  assign prod_p = (prod > 48'(POS_MAX)) ? POS_MAX : prod[24:0];

  // first triangle (z1-z2, z2-z3, s), second (z4-z3, z1-z4, s)
  always_comb begin
    if (state == S_NRM2) begin
      nvec.x = $signed({1'b0, z4}) - $signed({1'b0, z3});
      nvec.y = $signed({1'b0, z1}) - $signed({1'b0, z4});
    end else begin
      nvec.x = $signed({1'b0, z1}) - $signed({1'b0, z2});
      nvec.y = $signed({1'b0, z2}) - $signed({1'b0, z3});
    end
    nvec.z = $signed({2'b00, cell_size});
  end

  hvg_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nstart),
    .vec   (nvec),
    .done  (ndone),
    .nrm   (nres)
  );

  // vertex k of the cell
  assign sel_k = (state == S_EMIT) ? (vcnt + 3'd1) : 3'd0;
  always_comb begin
    unique case (sel_k)
      3'd0:    vsel = '{x: px0, y: py0, z: z1, h: cur_ul,    n: n1, last: 1'b0};
      3'd1:    vsel = '{x: px1, y: py0, z: z2, h: cur_left,  n: n1, last: 1'b0};
      3'd2:    vsel = '{x: px1, y: py1, z: z3, h: cur_h,     n: n1, last: 1'b0};
      3'd3:    vsel = '{x: px0, y: py0, z: z1, h: cur_ul,    n: n2, last: 1'b0};
      3'd4:    vsel = '{x: px1, y: py1, z: z3, h: cur_h,     n: n2, last: 1'b0};
      3'd5:    vsel = '{x: px0, y: py1, z: z4, h: cur_above, n: n2, last: 1'b1};
      default: vsel = '{x: px0, y: py1, z: z4, h: cur_above, n: n2, last: 1'b1};
    endcase
  end

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= RST_GRID_COLUMNS;
      grid_rows    <= RST_GRID_ROWS;
      cell_size    <= RST_CELL_SIZE;
      height_scale <= RST_HEIGHT_SCALE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_GRID_COLUMNS: grid_columns <= cfg.data[10:0];
        CFG_GRID_ROWS:    grid_rows    <= cfg.data[15:0];
        CFG_CELL_SIZE:    cell_size    <= cfg.data;
        CFG_HEIGHT_SCALE: height_scale <= cfg.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      upper_left   <= '0;
      left_sample  <= '0;
      column_index <= '0;
      row_index    <= '0;
      nstart       <= 1'b0;
      vertex.valid <= 1'b0;
      mcnt         <= '0;
      vcnt         <= '0;
    end else begin
      nstart <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            // line buffer read of c_eff issued this cycle
            cur_h    <= h_sat;
            cur_left <= left_sample;
            cur_ul   <= upper_left;
            cur_r    <= row_index;
            cur_c    <= c_eff;
            state    <= S_READ;
          end
        end
        S_READ: begin
          // above is here; new sample goes back to the same entry
          cur_above   <= above;
          upper_left  <= above;
          left_sample <= cur_h;
          if (col_wrap) begin
            column_index <= '0;
            row_index    <= (32'(cur_r) + 32'd1 >= 32'(rows)) ? 16'd0 : cur_r + 16'd1;
          end else begin
            column_index <= cur_c + COL_W'(1);
          end
          mcnt <= '0;
          if (cur_r != 16'd0 && cur_c != '0) begin
            state <= S_MUL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          unique case (mcnt)
            3'd0:    z1  <= prod_z;
            3'd1:    z2  <= prod_z;
            3'd2:    z3  <= prod_z;
            3'd3:    z4  <= prod_z;
            3'd4:    px0 <= prod_p;
            3'd5:    px1 <= prod_p;
            3'd6:    py0 <= prod_p;
            default: py1 <= prod_p;
          endcase
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd7) begin
            nstart <= 1'b1;
            state  <= S_NRM1;
          end
        end
        S_NRM1: begin
          if (ndone) begin
            n1     <= nres;
            nstart <= 1'b1;
            state  <= S_NRM2;
          end
        end
        S_NRM2: begin
          if (ndone) begin
            n2           <= nres;
            vcnt         <= '0;
            vertex.valid <= 1'b1;
            state        <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (vertex.ready) begin
            if (vcnt == 3'd5) begin
              vertex.valid <= 1'b0;
              state        <= S_IDLE;
            end else begin
              vcnt <= vcnt + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output payload register, loaded with the first vertex and on each take but the last
  always_ff @(posedge clk) begin
    if ((state == S_NRM2 && ndone) || (state == S_EMIT && vertex.ready && vcnt != 3'd5)) begin
      vertex.pos_x       <= vsel.x;
      vertex.pos_y       <= vsel.y;
      vertex.pos_z       <= vsel.z;
      vertex.colour_red  <= vsel.h;
      vertex.colour_blue <= ONE_Q15 - vsel.h;
      vertex.normal_x    <= (sel_k < 3'd3) ? n1.x : vsel.n.x;
      vertex.normal_y    <= (sel_k < 3'd3) ? n1.y : vsel.n.y;
      vertex.normal_z    <= (sel_k < 3'd3) ? n1.z : vsel.n.z;
      vertex.last        <= vsel.last;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(sample.ready && vertex.valid))
    else $error("sample taken while vertices pending");

  a_last_sixth: assert property (@(posedge clk) disable iff (rst)
    (vertex.valid && vertex.last) |-> (vcnt == 3'd5))
    else $error("last flag off the sixth vertex");

  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == S_READ))
    else $error("line buffer read slot missed");

  a_norm_done: assert property (@(posedge clk) disable iff (rst)
    ndone |-> (state == S_NRM1 || state == S_NRM2))
    else $error("normal result outside a normal pass");

endmodule

// ----- tb/tb_hvg_pkg.sv -----
`timescale 1ns / 100ps
// Vertex record and shared constant for the vertex generator testbench.
package tb_hvg_pkg;

  typedef struct {
    logic [24:0]        pos_x;
    logic [24:0]        pos_y;
    logic [24:0]        pos_z;
    logic [15:0]        colour_red;
    logic [15:0]        colour_blue;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               last;
  } vertex_t;

  localparam logic [15:0] TB_ONE = 16'd32768;

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the height map vertex generator core.
module tb_top import hvg_pkg::*, tb_hvg_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  hvg_in_if  sample ();
  hvg_out_if vertex ();
  hvg_cfg_if cfg ();

  heightmap_triangle_vertex_gen_core dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample.sink),
    .vertex (vertex.source),
    .cfg    (cfg.sink)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: registers, line buffer, neighbors and counters
  // ---------------------------------------------------------------------------
  logic [10:0] sh_cols;
  logic [15:0] sh_rows;
  logic [23:0] sh_cell;
  logic [23:0] sh_scale;
  logic [15:0] line_buf [MAX_COLUMNS];
  logic [15:0] left_h;
  logic [15:0] upleft_h;
  int unsigned col_at;
  int unsigned row_at;

  vertex_t vertex_q [$];   // vertices still owed by the block
  int      errors;
  int      fed_items;      // items accepted so far

  // sender/receiver idle percentages for the current phase
  int      send_idle;
  int      recv_idle;
  bit      recv_hold;      // long receiver hold-off in progress

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (item %0d)", what, got, want, fed_items);
    errors++;
  endtask

  function automatic logic [63:0] grid_at(input int unsigned idx);
    logic [63:0] p;
    p = 64'(idx) * 64'(sh_cell);
    return (p > 64'(POS_MAX)) ? 64'(POS_MAX) : p;
  endfunction

  function automatic logic [63:0] z_of(input logic [15:0] h);
    return (64'(h) * 64'(sh_scale)) >> 15;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // face normal scaled to Q1.15, half-up rounding, asymmetric saturation
  function automatic void face_normal(input longint v [3], output logic signed [15:0] n [3]);
    logic [63:0] m [3];
    logic [63:0] sq, root, q;
    int unsigned sh;
    sq = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      sq  += m[i] * m[i];
    end
    if (sq == 0) begin
      for (int i = 0; i < 3; i++) n[i] = 16'sd0;
      return;
    end
    while (sq < (64'd1 << 60)) begin
      sq <<= 2;
      sh++;
    end
    root = root64(sq);
    for (int i = 0; i < 3; i++) begin
      q = (((m[i] << sh) * 64'd65536) + root) / (64'd2 * root);
      if (v[i] < 0) begin
        if (q > 32768) q = 32768;
        n[i] = 16'(0 - q);
      end else begin
        if (q > 32767) q = 32767;
        n[i] = 16'(q);
      end
    end
  endfunction

  function automatic vertex_t mk_vertex(input int unsigned r, input int unsigned c,
                                        input logic [15:0] h,
                                        input logic signed [15:0] n [3], input bit lst);
    vertex_t vx;
    vx.pos_x       = 25'(grid_at(r));
    vx.pos_y       = 25'(grid_at(c));
    vx.pos_z       = 25'(z_of(h));
    vx.colour_red  = h;
    vx.colour_blue = TB_ONE - h;
    vx.normal_x    = n[0];
    vx.normal_y    = n[1];
    vx.normal_z    = n[2];
    vx.last        = lst;
    return vx;
  endfunction

  // Advance the shadow by one accepted sample and queue the cell's vertices.
  task automatic take_sample(input logic [15:0] raw);
    int unsigned cols, rows, c, r;
    logic [15:0] h, above;
    longint z1, z2, z3, z4, s;
    longint a [3];
    longint b [3];
    logic signed [15:0] n1 [3];
    logic signed [15:0] n2 [3];
    cols = (sh_cols < 2) ? 2 : ((sh_cols > MAX_COLUMNS) ? MAX_COLUMNS : sh_cols);
    rows = (sh_rows < 2) ? 2 : sh_rows;
    c    = (col_at >= MAX_COLUMNS) ? 0 : col_at;
    r    = row_at;
    h    = (raw > TB_ONE) ? TB_ONE : raw;
    above = line_buf[c];
    if (r >= 1 && c >= 1) begin
      z1 = longint'(z_of(upleft_h));
      z2 = longint'(z_of(left_h));
      z3 = longint'(z_of(h));
      z4 = longint'(z_of(above));
      s  = longint'(sh_cell);
      a[0] = z1 - z2; a[1] = z2 - z3; a[2] = s;
      b[0] = z4 - z3; b[1] = z1 - z4; b[2] = s;
      face_normal(a, n1);
      face_normal(b, n2);
      vertex_q.push_back(mk_vertex(r - 1, c - 1, upleft_h, n1, 1'b0));
      vertex_q.push_back(mk_vertex(r,     c - 1, left_h,   n1, 1'b0));
      vertex_q.push_back(mk_vertex(r,     c,     h,        n1, 1'b0));
      vertex_q.push_back(mk_vertex(r - 1, c - 1, upleft_h, n2, 1'b0));
      vertex_q.push_back(mk_vertex(r,     c,     h,        n2, 1'b0));
      vertex_q.push_back(mk_vertex(r - 1, c,     above,    n2, 1'b1));
    end
    upleft_h    = above;
    line_buf[c] = h;
    left_h      = h;
    if (c + 1 >= cols) begin
      col_at = 0;
      row_at = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_at = c + 1;
      row_at = r;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: receiver ready and field-by-field check
  // ---------------------------------------------------------------------------
  initial vertex.ready = 1'b0;

  always @(posedge clk) begin
    if (rst || recv_hold) begin
      vertex.ready <= 1'b0;
    end else begin
      vertex.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    vertex_t w;
    if (!rst && vertex.valid && vertex.ready) begin
      if (vertex_q.size() == 0) begin
        report("unexpected vertex", 64'(vertex.pos_x), 64'd0);
      end else begin
        w = vertex_q.pop_front();
        if (vertex.pos_x !== w.pos_x) report("pos_x", vertex.pos_x, w.pos_x);
        if (vertex.pos_y !== w.pos_y) report("pos_y", vertex.pos_y, w.pos_y);
        if (vertex.pos_z !== w.pos_z) report("pos_z", vertex.pos_z, w.pos_z);
        if (vertex.colour_red !== w.colour_red)
          report("colour_red", vertex.colour_red, w.colour_red);
        if (vertex.colour_blue !== w.colour_blue)
          report("colour_blue", vertex.colour_blue, w.colour_blue);
        if (vertex.normal_x !== w.normal_x) report("normal_x", vertex.normal_x, w.normal_x);
        if (vertex.normal_y !== w.normal_y) report("normal_y", vertex.normal_y, w.normal_y);
        if (vertex.normal_z !== w.normal_z) report("normal_z", vertex.normal_z, w.normal_z);
        if (vertex.last !== w.last) report("last", vertex.last, w.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side drivers
  // ---------------------------------------------------------------------------
  initial begin
    sample.valid  = 1'b0;
    sample.height = '0;
    cfg.valid     = 1'b0;
    cfg.index     = CFG_GRID_COLUMNS;
    cfg.data      = '0;
  end

  // Offer one item; idles at random first, holds valid until accepted.
  // The leading edge keeps the drop of valid and the next offer apart; the
  // block needs that cycle for its line buffer read anyway.
  task automatic send_sample(input logic [15:0] h);
    @(posedge clk);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    sample.valid  <= 1'b1;
    sample.height <= h;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    take_sample(h);
    fed_items++;
    sample.valid <= 1'b0;
  endtask

  // Register write; only issued with nothing in flight.
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_GRID_COLUMNS: sh_cols  = val[10:0];
      CFG_GRID_ROWS:    sh_rows  = val[15:0];
      CFG_CELL_SIZE:    sh_cell  = val;
      CFG_HEIGHT_SCALE: sh_scale = val;
      default: ;
    endcase
  endtask

  // Wait for every owed vertex, then cover a sample still in its line buffer read.
  task automatic drain;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_geometry(input int c, input int r, input int cs, input int hs);
    drain();
    write_reg(CFG_GRID_COLUMNS, 24'(c));
    write_reg(CFG_GRID_ROWS,    24'(r));
    write_reg(CFG_CELL_SIZE,    24'(cs));
    write_reg(CFG_HEIGHT_SCALE, 24'(hs));
  endtask

  // Random height: mostly legal, some saturating, some extremes.
  function automatic logic [15:0] rand_height();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'($urandom_range(65535));
    if (k == 1) return ($urandom_range(1)) ? 16'd0 : TB_ONE;
    return 16'($urandom_range(32768));
  endfunction

  // Directed rows: heights only; their vertices are checked against the shadow.
  typedef struct {
    logic [15:0] h;
  } stim_row_t;

  stim_row_t dir_rows [16] = '{
    '{16'd0}, '{16'd0}, '{16'd0},              // row 0 flat at zero
    '{16'd0}, '{16'd0}, '{16'd0},              // row 1: flat cells, normal (0,0,max)
    '{16'd32768}, '{16'd65535}, '{16'd32769},  // row 2: full height, saturating input
    '{16'd0}, '{16'd32768}, '{16'd1},          // row 0 of next frame, steep
    '{16'd32768}, '{16'd0}, '{16'd16384},      // steep both ways
    '{16'd32767}
  };

  initial begin
    int n;
    errors    = 0;
    fed_items = 0;
    send_idle = 0;
    recv_idle = 0;
    recv_hold = 1'b0;
    sh_cols   = RST_GRID_COLUMNS;
    sh_rows   = RST_GRID_ROWS;
    sh_cell   = RST_CELL_SIZE;
    sh_scale  = RST_HEIGHT_SCALE;
    for (int i = 0; i < MAX_COLUMNS; i++) line_buf[i] = '0;
    left_h   = '0;
    upleft_h = '0;
    col_at   = 0;
    row_at   = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values first: two samples of a 1024-wide row give no vertex.
    send_sample(16'd100);
    send_sample(16'd200);
    drain();
    // After reset nothing may be owed.
    if (vertex_q.size() != 0) report("reset_queue", vertex_q.size(), 0);

    // Restart at row 0 via a small frame: finish current row by clamped width.
    // Width 1 clamps to 2; col_at is 2 so it wraps on the next sample.
    set_geometry(1, 3, 19200, 3276800);
    send_sample(16'd0);   // c>=cols path, wraps to next row

    // Three columns, three rows: directed walk.
    set_geometry(3, 3, 19200, 3276800);
    while (col_at != 0) send_sample(16'd0);
    while (row_at != 0) begin
      send_sample(16'd0);
      while (col_at != 0) send_sample(16'd0);
    end
    foreach (dir_rows[i]) send_sample(dir_rows[i].h);

    // Zero cell size on a flat cell gives the zero normal.
    set_geometry(2, 2, 0, 0);
    repeat (6) send_sample(16'd5000);
    // Extremes of spacing and scale; positions stay just below saturation.
    set_geometry(2, 65535, 24'hFFFFFF, 24'hFFFFFF);
    repeat (6) send_sample(rand_height());
    // back to the frame origin before the width grows
    set_geometry(2, 2, 1, 0);
    while (col_at != 0 || row_at != 0) send_sample(rand_height());
    set_geometry(2047, 2, 1, 0);   // width clamps to MAX_COLUMNS
    repeat (4) send_sample(rand_height());
    // narrow again: column 4 lies past the width and wraps to row 1
    set_geometry(2, 2, 1, 0);
    while (col_at != 0 || row_at != 0) send_sample(rand_height());

    // Random phases; each setting begins at frame origin so the line buffer
    // is always written before it is read.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 29 : ((ph == 1) ? 53 : 0);
      recv_idle = (ph == 0) ? 53 : ((ph == 1) ? 29 : 0);
      for (int g = 0; g < 3; g++) begin
        set_geometry($urandom_range(2, 8), $urandom_range(2, 5),
                     ($urandom_range(3) == 0) ? $urandom_range(16777215)
                                              : $urandom_range(1, 40000),
                     ($urandom_range(3) == 0) ? $urandom_range(16777215)
                                              : $urandom_range(0, 4000000));
        n = 20 + $urandom_range(10);
        for (int k = 0; k < n; k++) send_sample(rand_height());
        while (col_at != 0 || row_at != 0) send_sample(rand_height());
      end
      // sender waits for all results before the next phase
      while (vertex_q.size() != 0) @(posedge clk);
    end

    // Long receiver hold-off while samples keep coming; input must stall.
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int k = 0; k < 12; k++) send_sample(rand_height());
    join

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run limit: ~350 items plus their processing, stalls and idling.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- heightmap_triangle_vertex_gen_core.f -----
rtl/hvg_pkg.sv
rtl/hvg_if.sv
rtl/hvg_ram.sv
rtl/hvg_norm.sv
rtl/heightmap_triangle_vertex_gen_core.sv
tb/tb_hvg_pkg.sv
tb/tb_top.sv
